[hw/rtl/euclidean_rhythm_generator_macros.svh]
// Assertion macros for the rhythm generator RTL.
// Each macro expands to a concurrent assertion clocked on clock and
// disabled during reset, and to nothing in a synthesis build.
`ifndef EUCLIDEAN_RHYTHM_GENERATOR_MACROS_SVH
`define EUCLIDEAN_RHYTHM_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS
`define ERG_ASSERT_IMP(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("rhythm generator check failed");
`define ERG_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("rhythm generator check failed");
`else
`define ERG_ASSERT_IMP(label, pre, post)
`define ERG_ASSERT_NEXT(label, pre, post)
`endif

`endif

[hw/rtl/erg_pkg.sv]
`timescale 1ns / 1ps

package erg_pkg;

   // Store geometry.
   localparam int MAX_STEPS          = 64;
   localparam int PATTERN_COUNT      = 16;
   localparam int TRACKS_PER_PATTERN = 8;

   // Field widths.
   localparam int LEN_W  = 7;
   localparam int POS_W  = 6;
   localparam int ROT_W  = 16;
   localparam int CNT_W  = $clog2(ROT_W);
   localparam int NOTE_W = 7;

   localparam logic [LEN_W-1:0]  MAX_LEN          = LEN_W'(MAX_STEPS);
   localparam logic [LEN_W-1:0]  FALLBACK_RESET   = 7'd16;
   localparam logic [NOTE_W-1:0] DEFAULT_VELOCITY = 7'd100;
   localparam logic [7:0]        NOTE_MASK        = 8'h7F;

   // Result of the shared subtract and compare unit.
   typedef struct packed {
      logic             ge;
      logic [LEN_W-1:0] diff;
   } sub_result_type;

endpackage

[hw/rtl/erg_sub_unit.sv]
`timescale 1ns / 1ps

// Shared subtractor: gives a - b and whether a is at least b.
module erg_sub_unit (
   input  logic [erg_pkg::LEN_W-1:0] a,
   input  logic [erg_pkg::LEN_W-1:0] b,
   output erg_pkg::sub_result_type   result
);

   logic [erg_pkg::LEN_W:0] wide;

   assign wide        = {1'b0, a} - {1'b0, b};
   assign result.ge   = ~wide[erg_pkg::LEN_W];
   assign result.diff = wide[erg_pkg::LEN_W-1:0];

endmodule

[hw/rtl/euclidean_rhythm_generator.sv]
// The bit-serial rotation modulo, a correction state and the step walk run in turn;
// a new request is taken only in idle, after the last result beat is registered. The
// modulo and the walk, one beat per cycle while the output slot is free, share one subtractor.
// Reset (synchronous, active high) returns to idle, drops rsp_tvalid and sets
// fallback_length to 16.
`timescale 1ns / 1ps

`include "euclidean_rhythm_generator_macros.svh"

module euclidean_rhythm_generator (
   input  logic        clock,
   input  logic        reset,

   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata, lowest bit up: pulse_count[7:0], step_count[15:8], rotation[31:16],
   // note_in[39:32], velocity_in[47:40].
   input  logic [47:0] req_tdata,
   // tuser, lowest bit up: pattern_index[3:0], track_index[6:4].
   input  logic [6:0]  req_tuser,

   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata, lowest bit up: step_position[5:0], hit[6], note_out[13:7],
   // velocity_out[20:14], new_length[27:21], zero pad[31:28].
   output logic [31:0] rsp_tdata,
   // tuser, lowest bit up: pattern_out[3:0], track_out[6:4].
   output logic [6:0]  rsp_tuser,
   output logic        rsp_tlast,

   // Configuration channel: fallback_length.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data
);

   localparam int LW = erg_pkg::LEN_W;
   localparam int PW = erg_pkg::POS_W;
   localparam int RW = erg_pkg::ROT_W;
   localparam int CW = erg_pkg::CNT_W;
   localparam int NW = erg_pkg::NOTE_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_FIX,
      S_RUN
   } state_type;

   state_type         state_ff, state_in;
   logic [LW-1:0]     fallback_ff, fallback_in;
   logic [LW-1:0]     steps_ff, steps_in;
   logic [LW-1:0]     pulses_ff, pulses_in;
   logic [LW-1:0]     acc_ff, acc_in;
   logic [LW-1:0]     idx_ff, idx_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [PW-1:0]     rem_ff, rem_in;
   logic [RW-1:0]     mag_ff, mag_in;
   logic              neg_ff, neg_in;
   logic [CW-1:0]     bit_cnt_ff, bit_cnt_in;
   logic [3:0]        pattern_ff, pattern_in;
   logic [2:0]        track_ff, track_in;
   logic [NW-1:0]     note_ff, note_in;
   logic [NW-1:0]     vel_ff, vel_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]     out_pos_ff, out_pos_in;
   logic              out_hit_ff, out_hit_in;
   logic [NW-1:0]     out_note_ff, out_note_in;
   logic [NW-1:0]     out_vel_ff, out_vel_in;
   logic [LW-1:0]     out_len_ff, out_len_in;
   logic              out_last_ff, out_last_in;
   logic [3:0]        out_pattern_ff, out_pattern_in;
   logic [2:0]        out_track_ff, out_track_in;

   // Request fields.
   logic [3:0]        req_pattern;
   logic [2:0]        req_track;
   logic signed [7:0] req_pulses;
   logic signed [7:0] req_steps;
   logic signed [RW-1:0] req_rotation;
   logic [7:0]        req_note;
   logic [7:0]        req_velocity;

   assign req_pulses   = req_tdata[7:0];
   assign req_steps    = req_tdata[15:8];
   assign req_rotation = req_tdata[31:16];
   assign req_note     = req_tdata[39:32];
   assign req_velocity = req_tdata[47:40];
   assign req_pattern  = req_tuser[3:0];
   assign req_track    = req_tuser[6:4];

   // Effective step count and pulse count of an incoming request. A step
   // count below one takes the fallback length, itself held to 1..MAX_STEPS.
   logic [LW-1:0] eff_steps;
   logic [LW-1:0] eff_pulses;
   logic          req_in_range;

   always_comb begin
      if (req_steps < 8'sd1) begin
         if (fallback_ff == '0) begin
            eff_steps = LW'(1);
         end else if (fallback_ff > erg_pkg::MAX_LEN) begin
            eff_steps = erg_pkg::MAX_LEN;
         end else begin
            eff_steps = fallback_ff;
         end
      end else if ({1'b0, req_steps[6:0]} > {1'b0, erg_pkg::MAX_LEN}) begin
         eff_steps = erg_pkg::MAX_LEN;
      end else begin
         eff_steps = req_steps[6:0];
      end

      if (req_pulses[7]) begin
         eff_pulses = '0;
      end else if (req_pulses[6:0] > eff_steps) begin
         eff_pulses = eff_steps;
      end else begin
         eff_pulses = req_pulses[6:0];
      end
   end

   assign req_in_range = (int'(req_pattern) < erg_pkg::PATTERN_COUNT) &&
                         (int'(req_track) < erg_pkg::TRACKS_PER_PATTERN);

   // The single subtract and compare unit. During the modulo it does one
   // restoring step per cycle, in the correction cycle it forms steps minus
   // remainder for a negative rotation, and during the step walk it tests
   // the Bresenham bucket against the step count.
   logic [LW-1:0]           sub_a;
   logic [LW-1:0]           sub_b;
   erg_pkg::sub_result_type sub_res;
   logic [LW-1:0]           div_part;
   logic [LW-1:0]           bucket_sum;

   assign div_part   = {rem_ff, mag_ff[RW-1]};
   assign bucket_sum = acc_ff + pulses_ff;

   always_comb begin
      case (state_ff)
         S_DIV: begin
            sub_a = div_part;
            sub_b = steps_ff;
         end
         S_FIX: begin
            sub_a = steps_ff;
            sub_b = {1'b0, rem_ff};
         end
         S_RUN: begin
            sub_a = bucket_sum;
            sub_b = steps_ff;
         end
         default: begin
            sub_a = '0;
            sub_b = '0;
         end
      endcase
   end

   erg_sub_unit u_sub (
      .a      (sub_a),
      .b      (sub_b),
      .result (sub_res)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   logic          out_slot_free;
   logic [PW-1:0] pos_next;

   assign out_slot_free = !rsp_valid_ff || rsp_tready;
   assign pos_next      = pos_ff + PW'(1);

   always_comb begin
      state_in       = state_ff;
      fallback_in    = fallback_ff;
      steps_in       = steps_ff;
      pulses_in      = pulses_ff;
      acc_in         = acc_ff;
      idx_in         = idx_ff;
      pos_in         = pos_ff;
      rem_in         = rem_ff;
      mag_in         = mag_ff;
      neg_in         = neg_ff;
      bit_cnt_in     = bit_cnt_ff;
      pattern_in     = pattern_ff;
      track_in       = track_ff;
      note_in        = note_ff;
      vel_in         = vel_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      out_pos_in     = out_pos_ff;
      out_hit_in     = out_hit_ff;
      out_note_in    = out_note_ff;
      out_vel_in     = out_vel_ff;
      out_len_in     = out_len_ff;
      out_last_in    = out_last_ff;
      out_pattern_in = out_pattern_ff;
      out_track_in   = out_track_ff;

      if (csr_valid) begin
         fallback_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            // A request whose pattern or track lies outside the store is
            // dropped without any result beat.
            if (req_tvalid && req_in_range) begin
               state_in   = S_DIV;
               steps_in   = eff_steps;
               pulses_in  = eff_pulses;
               pattern_in = req_pattern;
               track_in   = req_track;
               note_in    = NW'(req_note & erg_pkg::NOTE_MASK);
               vel_in     = (req_velocity != 8'd0) ? req_velocity[NW-1:0]
                                                   : erg_pkg::DEFAULT_VELOCITY;
               neg_in     = req_rotation[RW-1];
               mag_in     = req_rotation[RW-1] ? RW'(-req_rotation) : req_rotation;
               rem_in     = '0;
               bit_cnt_in = '0;
            end
         end
         S_DIV: begin
            // Remainder stays below the step count, so it fits in POS_W bits.
            rem_in     = sub_res.ge ? sub_res.diff[PW-1:0] : div_part[PW-1:0];
            mag_in     = {mag_ff[RW-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + CW'(1);
            if (bit_cnt_ff == CW'(RW - 1)) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            // Wrap a negative rotation into 0..steps-1.
            if (neg_ff && (rem_ff != '0)) begin
               pos_in = sub_res.diff[PW-1:0];
            end else begin
               pos_in = rem_ff;
            end
            acc_in = '0;
            idx_in = '0;
            state_in = S_RUN;
         end
         S_RUN: begin
            if (out_slot_free) begin
               rsp_valid_in   = 1'b1;
               out_pos_in     = pos_ff;
               out_hit_in     = sub_res.ge;
               out_note_in    = sub_res.ge ? note_ff : '0;
               out_vel_in     = sub_res.ge ? vel_ff : '0;
               out_len_in     = steps_ff;
               out_last_in    = (idx_ff == steps_ff - LW'(1));
               out_pattern_in = pattern_ff;
               out_track_in   = track_ff;
               acc_in         = sub_res.ge ? sub_res.diff : bucket_sum;
               idx_in         = idx_ff + LW'(1);
               pos_in         = ({1'b0, pos_next} == steps_ff) ? '0 : pos_next;
               if (idx_ff == steps_ff - LW'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fallback_ff  <= erg_pkg::FALLBACK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fallback_ff  <= fallback_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      steps_ff       <= steps_in;
      pulses_ff      <= pulses_in;
      acc_ff         <= acc_in;
      idx_ff         <= idx_in;
      pos_ff         <= pos_in;
      rem_ff         <= rem_in;
      mag_ff         <= mag_in;
      neg_ff         <= neg_in;
      bit_cnt_ff     <= bit_cnt_in;
      pattern_ff     <= pattern_in;
      track_ff       <= track_in;
      note_ff        <= note_in;
      vel_ff         <= vel_in;
      out_pos_ff     <= out_pos_in;
      out_hit_ff     <= out_hit_in;
      out_note_ff    <= out_note_in;
      out_vel_ff     <= out_vel_in;
      out_len_ff     <= out_len_in;
      out_last_ff    <= out_last_in;
      out_pattern_ff <= out_pattern_in;
      out_track_ff   <= out_track_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, out_len_ff, out_vel_ff, out_note_ff, out_hit_ff, out_pos_ff};
   assign rsp_tuser  = {out_track_ff, out_pattern_ff};
   assign rsp_tlast  = out_last_ff;

   // The rotated position always lies inside the track.
   `ERG_ASSERT_IMP(a_pos_in_track, rsp_valid_ff, {1'b0, out_pos_ff} < out_len_ff)
   // An empty step carries neither note nor velocity.
   `ERG_ASSERT_IMP(a_empty_step, rsp_valid_ff && !out_hit_ff, out_note_ff == '0 && out_vel_ff == '0)
   // While walking the steps, the bucket and step index stay below the step count.
   `ERG_ASSERT_IMP(a_walk_bounds, state_ff == S_RUN, acc_ff < steps_ff && idx_ff < steps_ff)
   // A beat that is not the last one means the walk is still going.
   `ERG_ASSERT_IMP(a_not_last_busy, rsp_valid_ff && rsp_tready && !out_last_ff, state_ff == S_RUN)
   // The walk starts with an empty bucket at step zero.
   `ERG_ASSERT_NEXT(a_walk_start, state_ff == S_FIX, acc_ff == '0 && idx_ff == '0)

endmodule

[sim/euclidean_rhythm_generator_tb.sv]
`timescale 1ns / 1ps

module euclidean_rhythm_generator_tb;

   // Longest stretch without any accepted beat before the run is declared hung.
   localparam int QUIET_LIMIT  = 3000;
   localparam int PHASE_COUNT  = 6;
   localparam int PHASE_ITEMS  = 44;
   localparam int UNTYPED      = -1;

   // One fill request as it travels on the request channel.
   typedef struct {
      logic [3:0]         pattern_index;
      logic [2:0]         track_index;
      logic signed [7:0]  pulse_count;
      logic signed [7:0]  step_count;
      logic signed [15:0] rotation;
      logic [7:0]         note_in;
      logic [7:0]         velocity_in;
      int                 known_length;   // typed-in track length, or UNTYPED
      int                 known_hits;     // typed-in number of hits, or UNTYPED
   } rhythm_request_type;

   // One step of the generated rhythm as it comes back on the result channel.
   typedef struct {
      logic [3:0] pattern;
      logic [2:0] track;
      logic [5:0] position;
      logic       hit;
      logic [6:0] note;
      logic [6:0] velocity;
      logic [6:0] length;
      logic       last;
   } step_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [6:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [6:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [6:0]  csr_data = '0;

   // Our own copy of the fallback_length register, updated on every accepted write.
   logic [6:0]         fallback_len = erg_pkg::FALLBACK_RESET;
   step_beat_type      expected_steps[$];
   rhythm_request_type stim_rows[$];
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;
   int                 mismatches = 0;
   int                 quiet_cycles = 0;

   euclidean_rhythm_generator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Bresenham bucket fill: the accumulator gains the pulse count each step and a
   // hit falls wherever it reaches the step count. Pushes one expected beat per step
   // and hands back the effective length and the number of hits for the table check.
   function automatic void plan_rhythm(input rhythm_request_type r, output int steps,
                                       output int hits);
      int            pulses;
      int            rot;
      int            acc;
      int            at;
      logic [6:0]    vel;
      step_beat_type b;
      steps  = int'(r.step_count);
      pulses = int'(r.pulse_count);
      rot    = int'(r.rotation);
      acc    = 0;
      hits   = 0;
      // A zero or negative step count falls back to the register, itself kept
      // within 1..MAX_STEPS.
      if (steps < 1) begin
         steps = int'(fallback_len);
         if (steps < 1) begin
            steps = 1;
         end
      end
      if (steps > erg_pkg::MAX_STEPS) begin
         steps = erg_pkg::MAX_STEPS;
      end
      if (pulses < 0) begin
         pulses = 0;
      end
      if (pulses > steps) begin
         pulses = steps;
      end
      // Only an input of exactly zero gets the default; 128 masks to zero and stays.
      vel = (r.velocity_in != 8'd0) ? r.velocity_in[6:0] : erg_pkg::DEFAULT_VELOCITY;
      for (int i = 0; i < steps; i++) begin
         b.hit = 1'b0;
         if (pulses > 0) begin
            acc += pulses;
            if (acc >= steps) begin
               acc -= steps;
               b.hit = 1'b1;
               hits++;
            end
         end
         // Truncating remainder, then pulled back into 0..steps-1.
         at = (i + rot) % steps;
         if (at < 0) begin
            at += steps;
         end
         b.pattern  = r.pattern_index;
         b.track    = r.track_index;
         b.position = at[5:0];
         b.note     = b.hit ? 7'(r.note_in & erg_pkg::NOTE_MASK) : 7'd0;
         b.velocity = b.hit ? vel : 7'd0;
         b.length   = steps[6:0];
         b.last     = (i == steps - 1);
         expected_steps.push_back(b);
      end
   endfunction

   function automatic void add_row(input int pattern, input int track, input int pulses,
                                   input int steps, input int rot, input int note,
                                   input int vel, input int len, input int hits);
      rhythm_request_type r;
      r.pattern_index = 4'(pattern);
      r.track_index   = 3'(track);
      r.pulse_count   = 8'(pulses);
      r.step_count    = 8'(steps);
      r.rotation      = 16'(rot);
      r.note_in       = 8'(note);
      r.velocity_in   = 8'(vel);
      r.known_length  = len;
      r.known_hits    = hits;
      stim_rows.push_back(r);
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Presents one request, holding tvalid high across back-to-back beats. Within this
   // task the valid line is only lowered when the sender decides to idle first.
   task automatic send_request(input rhythm_request_type r, output int len,
                               output int hits);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {r.velocity_in, r.note_in, r.rotation, r.step_count, r.pulse_count};
      req_tuser  <= {r.track_index, r.pattern_index};
      do @(posedge clock); while (!req_tready);
      plan_rhythm(r, len, hits);
   endtask

   // Holds the request channel quiet until every predicted step beat has come
   // back, then lets the block settle.
   task automatic wait_for_drain(input int settle);
      req_tvalid <= 1'b0;
      while (expected_steps.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_fallback(input logic [6:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      fallback_len  = value;
   endtask

   // Result side: random back-pressure, and every accepted beat is compared
   // field by field against the oldest predicted step.
   always @(posedge clock) begin
      step_beat_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_steps.size() == 0) begin
               $display("%0t: unexpected step beat, expected none, got tdata %h tuser %h",
                        $time, rsp_tdata, rsp_tuser);
               mismatches++;
            end else begin
               want = expected_steps.pop_front();
               check_field("pattern_out",   int'(want.pattern),  int'(rsp_tuser[3:0]));
               check_field("track_out",     int'(want.track),    int'(rsp_tuser[6:4]));
               check_field("step_position", int'(want.position), int'(rsp_tdata[5:0]));
               check_field("hit",           int'(want.hit),      int'(rsp_tdata[6]));
               check_field("note_out",      int'(want.note),     int'(rsp_tdata[13:7]));
               check_field("velocity_out",  int'(want.velocity), int'(rsp_tdata[20:14]));
               check_field("new_length",    int'(want.length),   int'(rsp_tdata[27:21]));
               check_field("last",          int'(want.last),     int'(rsp_tlast));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Hang detection: any accepted beat on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      rhythm_request_type r;
      int                 len;
      int                 hits;
      int                 eff;
      int                 pick;
      logic [6:0]         phase_fallback[4];
      phase_fallback = '{7'd127, 7'd0, 7'd64, 7'd1};

      // Directed rows run with the reset fallback length of 16.
      //      pat trk pulses steps rotation note vel  length hits
      add_row(0,  0,  4,     0,    0,       60,  90,  16,    4);       // zero steps use fallback
      add_row(15, 7,  127,   -128, 0,       127, 127, 16,    16);      // most negative steps
      add_row(5,  3,  127,   127,  0,       64,  64,  64,    64);      // steps saturate, all hits
      add_row(1,  1,  -128,  64,   0,       10,  20,  64,    0);       // negative pulses, no hits
      add_row(2,  2,  1,     1,    -32768,  255, 1,   1,     1);       // single step, low rotation
      add_row(3,  4,  3,     8,    32767,   255, 0,   8,     3);       // velocity zero gives 100
      add_row(4,  5,  5,     8,    -1,      200, 128, 8,     5);       // velocity masks to zero
      add_row(6,  6,  0,     5,    3,       50,  50,  5,     0);       // zero pulses
      add_row(7,  0,  13,    13,   -13,     128, 255, 13,    13);      // pulses equal steps
      add_row(8,  1,  7,     16,   -300,    36,  99,  UNTYPED, UNTYPED);
      add_row(9,  2,  62,    63,   12345,   72,  64,  UNTYPED, UNTYPED);
      add_row(10, 3,  1,     65,   100,     1,   1,   64,    1);       // just above the store size
      add_row(11, 4,  -1,    -1,   -5,      0,   0,   16,    0);
      add_row(12, 5,  17,    40,   -32768,  85,  255, UNTYPED, UNTYPED);
      add_row(13, 6,  9,     12,   7,       127, 127, UNTYPED, UNTYPED);
      add_row(14, 7,  100,   3,    2,       33,  44,  3,     3);       // pulses above steps

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct  = 12;
      recv_stall_pct = 74;
      foreach (stim_rows[k]) begin
         send_request(stim_rows[k], len, hits);
         if (stim_rows[k].known_length != UNTYPED) begin
            check_field("row length", stim_rows[k].known_length, len);
            check_field("row hits", stim_rows[k].known_hits, hits);
         end
      end

      // Random phases. Each starts from an idle block with a fresh fallback
      // length: the extremes first, then random values. The idle pattern moves
      // from a slow receiver to a slow sender and finally to full rate.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_for_drain(24);
         write_fallback((phase < 4) ? phase_fallback[phase] : 7'($urandom));
         send_idle_pct  = (phase < 2) ? 12 : (phase < 4) ? 74 : 0;
         recv_stall_pct = (phase < 2) ? 74 : (phase < 4) ? 12 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r.pattern_index = 4'($urandom);
            r.track_index   = 3'($urandom);
            r.rotation      = 16'($urandom);
            r.note_in       = 8'($urandom);
            r.velocity_in   = ($urandom_range(9) == 0) ? 8'($urandom_range(1) << 7)
                                                        : 8'($urandom);
            // Mostly short, well-formed tracks; some use the fallback, a few run
            // long, and a tenth are any byte at all.
            pick = $urandom_range(99);
            if (pick < 10) begin
               r.step_count = 8'($urandom);
            end else if (pick < 25) begin
               r.step_count = 8'(-int'($urandom_range(128)));
            end else if (pick < 85) begin
               r.step_count = 8'($urandom_range(16, 1));
            end else begin
               r.step_count = 8'($urandom_range(64, 17));
            end
            eff = (r.step_count < 1) ? 64 : int'(r.step_count);
            r.pulse_count = ($urandom_range(4) == 0) ? 8'($urandom)
                                                      : 8'($urandom_range(eff > 64 ? 64 : eff));
            // Once per phase the sender holds off until the block has gone idle.
            if (n == 20) begin
               wait_for_drain(1);
            end
            send_request(r, len, hits);
         end
      end

      wait_for_drain(40);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/erg_pkg.sv
hw/rtl/erg_sub_unit.sv
hw/rtl/euclidean_rhythm_generator.sv
sim/euclidean_rhythm_generator_tb.sv
